// ===== design/dtn_pkg.sv =====
// shared types, constants and helpers of the depth to normal map block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtn_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int DEPTH_BITS   = 16;
    localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
    localparam int GEOM_BITS    = 11;
    localparam int GAIN_BITS    = 16;
    localparam int MAG_BITS     = 32;
    localparam int QUOT_BITS    = 17;

    localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SLOPE_GAIN   = 2'd2;
    localparam logic [1:0] REG_CLIP_RAW     = 2'd3;

    typedef struct packed {
        logic       background;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } dtn_pix_t;

    typedef struct packed {
        logic                  start;
        logic [DEPTH_BITS-1:0] dx;
        logic [DEPTH_BITS-1:0] dy;
        logic                  nx;
        logic                  ny;
    } dtn_req_t;

    function automatic logic [7:0] to_channel(input logic [QUOT_BITS-1:0] nm,
                                              input logic neg);
        logic [17:0] biased;
        logic [25:0] prod;
        biased = neg ? (18'd65536 - {1'b0, nm}) : (18'd65536 + {1'b0, nm});
        prod   = ({biased, 8'd0}) - {8'd0, biased};
        return prod[24:17];
    endfunction

endpackage

`default_nettype wire

// ===== design/dtn_line_store.sv =====
// previous-row depth store, one write and one registered read port
// uses dtn_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtn_line_store (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [dtn_pkg::ADDR_BITS-1:0]  waddr,
    input  wire logic [dtn_pkg::DEPTH_BITS-1:0] wdata,
    input  wire logic [dtn_pkg::ADDR_BITS-1:0]  raddr,
    output logic      [dtn_pkg::DEPTH_BITS-1:0] rdata
);
    import dtn_pkg::*;

    logic [DEPTH_BITS-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/dtn_norm_core.sv =====
// normal vector unit: gain multiply, range shift, squares, iterative square root,
// iterative division and channel remap; uses dtn_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtn_norm_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dtn_pkg::dtn_req_t             req,
    input  wire logic [dtn_pkg::GAIN_BITS-1:0] gain,
    output logic                               done,
    output dtn_pkg::dtn_pix_t                  pix
);
    import dtn_pkg::*;

    typedef enum logic [7:0] {
        C_IDLE  = 8'b00000001,
        C_MUL   = 8'b00000010,
        C_SHIFT = 8'b00000100,
        C_SQR   = 8'b00001000,
        C_SUM   = 8'b00010000,
        C_SQRT  = 8'b00100000,
        C_DIV   = 8'b01000000,
        C_DONE  = 8'b10000000
    } core_state_t;

    core_state_t state_reg, state_next;

    logic [DEPTH_BITS-1:0] dx_reg, dy_reg;
    logic                  nx_reg, ny_reg;
    logic [MAG_BITS-1:0]   ax_reg, ay_reg, az_reg;
    logic [59:0]           sx_reg, sy_reg, sz_reg;
    logic [63:0]           v_reg, res_reg, bit_reg;
    logic [MAG_BITS-1:0]   q_reg;
    logic [MAG_BITS-1:0]   rx_reg, ry_reg, rz_reg;
    logic [QUOT_BITS-1:0]  qx_reg, qy_reg, qz_reg;
    logic [4:0]            cnt_reg;

    logic [MAG_BITS-1:0]   mxy;
    logic [1:0]            sh;
    logic [63:0]           trial;
    logic [MAG_BITS-1:0]   tx, ty, tz;
    logic                  bx, by, bz;

    always_comb
    begin
        mxy   = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        sh    = mxy[31] ? 2'd2 : (mxy[30] ? 2'd1 : 2'd0);
        trial = res_reg + bit_reg;
        tx    = (cnt_reg == 5'd0) ? rx_reg : {rx_reg[MAG_BITS-2:0], 1'b0};
        ty    = (cnt_reg == 5'd0) ? ry_reg : {ry_reg[MAG_BITS-2:0], 1'b0};
        tz    = (cnt_reg == 5'd0) ? rz_reg : {rz_reg[MAG_BITS-2:0], 1'b0};
        bx    = (tx >= q_reg);
        by    = (ty >= q_reg);
        bz    = (tz >= q_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:  if (req.start) state_next = C_MUL;
            C_MUL:   state_next = C_SHIFT;
            C_SHIFT: state_next = C_SQR;
            C_SQR:   state_next = C_SUM;
            C_SUM:   state_next = C_SQRT;
            C_SQRT:  if (bit_reg[0]) state_next = C_DIV;
            C_DIV:   if (cnt_reg == 5'd16) state_next = C_DONE;
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                dx_reg <= req.dx;
                dy_reg <= req.dy;
                nx_reg <= req.nx;
                ny_reg <= req.ny;
            end
            C_MUL:
            begin
                ax_reg <= MAG_BITS'(dx_reg * gain);
                ay_reg <= MAG_BITS'(dy_reg * gain);
                az_reg <= MAG_BITS'(256);
            end
            C_SHIFT:
            begin
                ax_reg <= ax_reg >> sh;
                ay_reg <= ay_reg >> sh;
                az_reg <= az_reg >> sh;
            end
            C_SQR:
            begin
                sx_reg <= ax_reg[29:0] * ax_reg[29:0];
                sy_reg <= ay_reg[29:0] * ay_reg[29:0];
                sz_reg <= az_reg[29:0] * az_reg[29:0];
            end
            C_SUM:
            begin
                v_reg   <= {4'd0, sx_reg} + {4'd0, sy_reg} + {4'd0, sz_reg};
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            C_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= '0;
                rx_reg  <= ax_reg;
                ry_reg  <= ay_reg;
                rz_reg  <= az_reg;
                if (bit_reg[0])
                begin
                    q_reg <= (v_reg >= trial) ? ((res_reg[MAG_BITS:1]) + bit_reg[MAG_BITS-1:0])
                                              : res_reg[MAG_BITS:1];
                end
            end
            C_DIV:
            begin
                rx_reg  <= bx ? tx - q_reg : tx;
                ry_reg  <= by ? ty - q_reg : ty;
                rz_reg  <= bz ? tz - q_reg : tz;
                qx_reg  <= {qx_reg[QUOT_BITS-2:0], bx};
                qy_reg  <= {qy_reg[QUOT_BITS-2:0], by};
                qz_reg  <= {qz_reg[QUOT_BITS-2:0], bz};
                cnt_reg <= cnt_reg + 5'd1;
            end
            C_DONE:
            begin
                cnt_reg <= '0;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done           = (state_reg == C_DONE);
    assign pix.red        = to_channel(qx_reg, nx_reg);
    assign pix.green      = to_channel(qy_reg, ny_reg);
    assign pix.blue       = to_channel(qz_reg, 1'b0);
    assign pix.background = 1'b0;

endmodule

`default_nettype wire

// ===== design/depth_to_normal_map_top.sv =====
// depth to normal map top level: stream ports, config registers, counters, control
// uses dtn_pkg, dtn_line_store, dtn_norm_core
`timescale 1ns / 1ps
`default_nettype none

// flow: background pixels pass T_READ then T_OUT, others also wait in T_CALC
// for the normal unit, whose square root (32 steps) and division (17 steps) run
// one transaction at a time; a new sample is taken once the output is loaded
// reset: counters, left neighbour and registers return to defaults; the line
// store is not cleared and is written before it is read in any frame
module depth_to_normal_map_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // depth_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // blue [23:16], green [15:8], red [7:0]
    output logic             m_tuser,   // background
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import dtn_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_READ = 4'b0010,
        T_CALC = 4'b0100,
        T_OUT  = 4'b1000
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [GEOM_BITS-1:0]  width_reg, height_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [DEPTH_BITS-1:0] clip_reg;
    logic [ADDR_BITS-1:0]  col_reg;
    logic [ROW_BITS-1:0]   row_reg;
    logic [DEPTH_BITS-1:0] left_reg;
    logic [DEPTH_BITS-1:0] d_reg, lft_reg;
    logic [ADDR_BITS-1:0]  wcol_reg;
    logic                  bg_reg;
    logic                  mvalid_reg;
    dtn_pix_t              out_reg, res_reg;

    logic [GEOM_BITS-1:0]  w_sat, h_sat;
    logic                  accept;
    logic [DEPTH_BITS-1:0] top;
    dtn_req_t              req;
    logic                  core_done;
    dtn_pix_t              core_pix;
    logic                  load;

    assign w_sat  = (width_reg < GEOM_BITS'(2)) ? GEOM_BITS'(2)
                  : ((width_reg > GEOM_BITS'(MAX_WIDTH)) ? GEOM_BITS'(MAX_WIDTH) : width_reg);
    assign h_sat  = (height_reg < GEOM_BITS'(2)) ? GEOM_BITS'(2)
                  : ((height_reg > GEOM_BITS'(MAX_HEIGHT)) ? GEOM_BITS'(MAX_HEIGHT)
                  : height_reg);
    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == T_OUT) && (!mvalid_reg || m_tready);

    dtn_line_store u_store (
        .clk   (clk),
        .we    (state_reg == T_READ),
        .waddr (wcol_reg),
        .wdata (d_reg),
        .raddr (col_reg),
        .rdata (top)
    );

    always_comb
    begin
        req.start = (state_reg == T_READ) && !bg_reg;
        req.nx    = lft_reg < d_reg;
        req.ny    = top < d_reg;
        req.dx    = req.nx ? d_reg - lft_reg : lft_reg - d_reg;
        req.dy    = req.ny ? d_reg - top : top - d_reg;
    end

    dtn_norm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .gain  (gain_reg),
        .done  (core_done),
        .pix   (core_pix)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:  if (accept) state_next = T_READ;
            T_READ:  state_next = bg_reg ? T_OUT : T_CALC;
            T_CALC:  if (core_done) state_next = T_OUT;
            T_OUT:   if (load) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            width_reg  <= GEOM_BITS'(640);
            height_reg <= GEOM_BITS'(480);
            gain_reg   <= GAIN_BITS'(256);
            clip_reg   <= DEPTH_BITS'(1000);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_LINE_WIDTH:   width_reg  <= cfg_wdata[GEOM_BITS-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_wdata[GEOM_BITS-1:0];
                    REG_SLOPE_GAIN:   gain_reg   <= cfg_wdata;
                    REG_CLIP_RAW:     clip_reg   <= cfg_wdata;
                    default:          clip_reg   <= clip_reg;
                endcase
            end
            if (accept)
            begin
                left_reg <= s_tdata;
                if (({1'b0, col_reg} + GEOM_BITS'(1)) >= w_sat)
                begin
                    col_reg <= '0;
                    row_reg <= (({1'b0, row_reg} + GEOM_BITS'(1)) >= h_sat) ? '0
                             : row_reg + ROW_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + ADDR_BITS'(1);
                end
            end
            if (load)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg    <= s_tdata;
            lft_reg  <= left_reg;
            wcol_reg <= col_reg;
            bg_reg   <= (row_reg == '0) || (col_reg == '0) || (s_tdata == '0)
                     || (s_tdata > clip_reg);
        end
        if (state_reg == T_READ)
        begin
            res_reg <= '{background: 1'b1, blue: 8'd0, green: 8'd0, red: 8'd0};
        end
        else if (core_done)
        begin
            res_reg <= core_pix;
        end
        if (load)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red};
    assign m_tuser  = out_reg.background;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for depth_to_normal_map_top: stream stimulus, config phases
// and an in-bench normal-map predictor; depends on dtn_pkg and the design files
`timescale 1ns / 1ps

module testbench;
    import dtn_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    depth_to_normal_map_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [15:0] prev_row [MAX_WIDTH];
    logic [15:0] left_px;
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_gain;
    int unsigned cfg_clip;

    dtn_pix_t    pixel_q[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] remap(input longint unsigned mag, input bit neg,
                                         input longint unsigned q);
        longint unsigned nm;
        longint unsigned biased;
        nm = (mag << 16) / q;
        if (nm > 65536) nm = 65536;
        biased = neg ? (65536 - nm) : (65536 + nm);
        return 8'((255 * biased) >> 17);
    endfunction

    function automatic dtn_pix_t predict_pixel(input logic [15:0] d);
        dtn_pix_t        p;
        int unsigned     w;
        int unsigned     h;
        int unsigned     top;
        bit              nx;
        bit              ny;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned az;
        longint unsigned m;
        longint unsigned q;
        w = cfg_width < 2 ? 2 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
        h = cfg_height < 2 ? 2 : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
        top = (col_cnt < MAX_WIDTH) ? prev_row[col_cnt] : 0;
        p = '0;
        if (row_cnt == 0 || col_cnt == 0 || d == 0 || d > cfg_clip)
            p.background = 1'b1;
        else
        begin
            nx = left_px < d;
            ny = top < d;
            ax = longint'(nx ? d - left_px : left_px - d) * cfg_gain;
            ay = longint'(ny ? d - top : top - d) * cfg_gain;
            az = 256;
            forever
            begin
                m = ax > ay ? ax : ay;
                if (az > m) m = az;
                if (m < (64'd1 << 30)) break;
                ax >>= 1;
                ay >>= 1;
                az >>= 1;
            end
            q = int_sqrt(ax * ax + ay * ay + az * az);
            if (q == 0) q = 1;
            p.red   = remap(ax, nx, q);
            p.green = remap(ay, ny, q);
            p.blue  = remap(az, 1'b0, q);
        end
        if (col_cnt < MAX_WIDTH) prev_row[col_cnt] = d;
        left_px = d;
        if (col_cnt + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end
        else
            col_cnt++;
        return p;
    endfunction

    // sender: one transaction, prediction on acceptance; tvalid stays up until
    // the next idle cycle or the end of the sequence
    task automatic send_depth(input logic [15:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        pixel_q.push_back(predict_pixel(d));
    endtask

    // receiver and checker
    always @(posedge clk)
    begin
        dtn_pix_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
                report_mismatch("unexpected pixel", m_tdata, 0);
            else
            begin
                want = pixel_q.pop_front();
                if (m_tdata[7:0] != want.red)
                    report_mismatch("red", m_tdata[7:0], want.red);
                if (m_tdata[15:8] != want.green)
                    report_mismatch("green", m_tdata[15:8], want.green);
                if (m_tdata[23:16] != want.blue)
                    report_mismatch("blue", m_tdata[23:16], want.blue);
                if (m_tuser != want.background)
                    report_mismatch("background", m_tuser, want.background);
            end
        end
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // write one register while idle; the frame counters do not start over when geometry changes
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LINE_WIDTH:   cfg_width  = val & 16'h7ff;
            REG_FRAME_HEIGHT: cfg_height = val & 16'h7ff;
            REG_SLOPE_GAIN:   cfg_gain   = val;
            REG_CLIP_RAW:     cfg_clip   = val;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_depth(input int unsigned base);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return 16'd0;
        if (r < 10) return 16'($urandom);
        if (r < 15) return 16'(cfg_clip + $urandom_range(3));
        return 16'(base + $urandom_range(40) - 20);
    endfunction

    // n_items need not fill whole frames; finish_frame then aligns the counters between phases
    task automatic send_frames(input int n_items, input int unsigned base);
        int k;
        for (k = 0; k < n_items; k++)
            send_depth(rand_depth(base));
    endtask

    task automatic finish_frame();
        while (!(col_cnt == 0 && row_cnt == 0))
            send_depth(rand_depth(500));
    endtask

    task automatic test_directed();
        write_reg(REG_LINE_WIDTH, 16'd4);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        send_depth(16'd100);
        send_depth(16'd200);
        send_depth(16'd300);
        send_depth(16'd400);
        send_depth(16'd500);
        send_depth(16'd1);
        send_depth(16'd0);
        send_depth(16'd1000);
        send_depth(16'd1001);
        send_depth(16'd999);
        send_depth(16'd500);
        send_depth(16'd500);
        wait_drained();
        write_reg(REG_CLIP_RAW, 16'hffff);
        write_reg(REG_SLOPE_GAIN, 16'hffff);
        send_depth(16'hffff);
        send_depth(16'h0001);
        send_depth(16'hffff);
        send_depth(16'h8000);
        send_depth(16'h0001);
        send_depth(16'hffff);
        send_depth(16'h0001);
        send_depth(16'h7fff);
        finish_frame();
        wait_drained();
    endtask

    // the wide-row phase stops part way through its first row, so the next
    // geometry takes effect mid-frame
    task automatic test_random_settings();
        int ph;
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            write_reg(REG_LINE_WIDTH, ph == 7 ? 16'd1024 : 16'($urandom_range(2, 12)));
            write_reg(REG_FRAME_HEIGHT, ph == 6 ? 16'd2 : 16'($urandom_range(2, 8)));
            write_reg(REG_SLOPE_GAIN, ph == 5 ? 16'd1 : 16'($urandom_range(1, 65535)));
            write_reg(REG_CLIP_RAW, ph == 4 ? 16'd0 : 16'($urandom_range(200, 65535)));
            send_frames(60, $urandom_range(30, 150) * 100);
            if (ph != 7)
                finish_frame();
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_LINE_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        write_reg(REG_CLIP_RAW, 16'd4000);
        hold_cycles = 600;
        send_frames(20, 2000);
        finish_frame();
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_LINE_WIDTH;
        cfg_wdata      = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        foreach (prev_row[i]) prev_row[i] = '0;
        left_px    = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        cfg_width  = 640;
        cfg_height = 480;
        cfg_gain   = 256;
        cfg_clip   = 1000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_settings();
        test_backpressure();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dtn_pkg.sv
design/dtn_line_store.sv
design/dtn_norm_core.sv
design/depth_to_normal_map_top.sv
verif/testbench.sv
